// ===== rtl/generational_slot_allocator_top_defines.svh =====
// Assertion macros used by the slot allocator datapath.
// Needs a clk and an active-low arst_n in scope where a macro is used.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define GSA_ASSERT_IMP(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define GSA_ASSERT_NXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== rtl/gsa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the slot allocator.
// No dependencies.
`default_nettype none

package gsa_pkg;

	localparam int NUM_SLOTS    = 64;
	localparam int VERSION_BITS = 16;

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int ID_W   = 7;
	localparam int VER_W  = VERSION_BITS;
	localparam int FUNC_W = 2;
	localparam int ST_W   = 2;
	localparam int CMP_W  = (ID_W > CNT_W) ? ID_W : CNT_W;

	localparam int IN_DATA_W  = ((ID_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ID_W + VER_W + 1 + 7) / 8) * 8;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_CREATE  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DESTROY = 2'd1;
	localparam logic [FUNC_W-1:0] FN_LOOKUP  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	// result selection
	localparam logic [1:0] RES_EMPTY     = 2'd0;
	localparam logic [1:0] RES_NOT_FOUND = 2'd1;
	localparam logic [1:0] RES_FULL      = 2'd2;
	localparam logic [1:0] RES_SLOT      = 2'd3;

	// version register update
	localparam logic [1:0] VER_HOLD = 2'd0;
	localparam logic [1:0] VER_ZERO = 2'd1;
	localparam logic [1:0] VER_RD   = 2'd2;
	localparam logic [1:0] VER_INC  = 2'd3;

	typedef struct packed {
		logic       take;
		logic       ptr_load_id;
		logic       ptr_inc;
		logic       ram_we;
		logic [1:0] ver_op;
		logic       flag_set;
		logic       flag_clr;
		logic       flags_clr_all;
		logic       issued_inc;
		logic       issued_clr;
		logic       out_load;
		logic [1:0] res_sel;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              id_valid;
		logic              ptr_at_end;
		logic              full;
		logic              flag_at_ptr;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/gsa_ram.sv =====
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
`default_nettype none

module gsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/gsa_ctrl.sv =====
// Sequencing state machine of the slot allocator: accepts a request, decodes it, runs
// the scan and RAM read its operation needs, then fills the output register. Uses gsa_pkg.
`default_nettype none

module gsa_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire gsa_pkg::sts_t sts,
	output gsa_pkg::cmd_t     cmd
);
	import gsa_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_RD     = 3'd3;
	localparam logic [2:0] S_CAPT   = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] res_q, res_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res_sel = res_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					FN_CREATE: state_d = S_SCAN;
					FN_CLEAR: begin
						cmd.flags_clr_all = 1'b1;
						cmd.issued_clr    = 1'b1;
						res_d             = RES_EMPTY;
						state_d           = S_OUT;
					end
					default: begin
						if (sts.id_valid) begin
							cmd.ptr_load_id = 1'b1;
							state_d         = S_RD;
						end else begin
							res_d   = RES_NOT_FOUND;
							state_d = S_OUT;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (sts.ptr_at_end) begin
					if (sts.full) begin
						res_d = RES_FULL;
					end else begin
						// issue a fresh id at the end of the issued range
						cmd.ram_we     = 1'b1;
						cmd.ver_op     = VER_ZERO;
						cmd.flag_set   = 1'b1;
						cmd.issued_inc = 1'b1;
						res_d          = RES_SLOT;
					end
					state_d = S_OUT;
				end else if (!sts.flag_at_ptr) begin
					state_d = S_RD;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_RD: state_d = S_CAPT;
			S_CAPT: begin
				if (sts.func == FN_CREATE) begin
					cmd.ver_op   = VER_INC;
					cmd.ram_we   = 1'b1;
					cmd.flag_set = 1'b1;
				end else begin
					cmd.ver_op   = VER_RD;
					cmd.flag_clr = (sts.func == FN_DESTROY);
				end
				res_d   = RES_SLOT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_EMPTY;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gsa_datapath.sv =====
// Datapath of the slot allocator: active flags, issued count, slot pointer, version RAM
// and the output register. Uses gsa_pkg, gsa_ram and the assertion macro header.
`default_nettype none
`include "generational_slot_allocator_top_defines.svh"

module gsa_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [gsa_pkg::FUNC_W-1:0] func,
	input  wire logic [gsa_pkg::ID_W-1:0]   entity_id,
	input  wire gsa_pkg::cmd_t            cmd,
	output gsa_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [gsa_pkg::ST_W-1:0]      status,
	output logic [gsa_pkg::ID_W-1:0]      result_id,
	output logic [gsa_pkg::VER_W-1:0]     version,
	output logic                          is_active
);
	import gsa_pkg::*;

	logic [FUNC_W-1:0]    func_q;
	logic [ID_W-1:0]      id_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     issued_q;
	logic [NUM_SLOTS-1:0] flags_q;
	logic [VER_W-1:0]     ver_q, ver_d;
	logic [VER_W-1:0]     ram_rdata;
	logic                 out_valid_q;
	logic [ST_W-1:0]      st_o_q;
	logic [ID_W-1:0]      id_o_q;
	logic [VER_W-1:0]     ver_o_q;
	logic                 act_o_q;
	logic [SLOT_W-1:0]    slot;
	logic                 ptr_at_end, full;

	assign slot       = ptr_q[SLOT_W-1:0];
	assign ptr_at_end = (ptr_q == issued_q);
	assign full       = (issued_q == CNT_W'(NUM_SLOTS));

	assign sts.func        = func_q;
	assign sts.id_valid    = (id_q != '0) && (CMP_W'(id_q) <= CMP_W'(issued_q));
	assign sts.ptr_at_end  = ptr_at_end;
	assign sts.full        = full;
	assign sts.flag_at_ptr = flags_q[slot];
	assign sts.out_free    = !out_valid_q || m_tready;

	always_comb begin
		case (cmd.ver_op)
			VER_ZERO: ver_d = '0;
			VER_RD:   ver_d = ram_rdata;
			VER_INC:  ver_d = ram_rdata + VER_W'(1);
			default:  ver_d = ver_q;
		endcase
	end

	gsa_ram #(
		.WIDTH(VER_W),
		.DEPTH(NUM_SLOTS)
	) u_ver_ram (
		.clk  (clk),
		.we   (cmd.ram_we),
		.addr (slot),
		.wdata(ver_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			issued_q <= '0;
			flags_q  <= '0;
			func_q   <= FN_CREATE;
		end else begin
			if (cmd.take) begin
				func_q <= func;
				ptr_q  <= '0;
			end else if (cmd.ptr_load_id) begin
				ptr_q <= CNT_W'(id_q - ID_W'(1));
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.issued_clr) begin
				issued_q <= '0;
			end else if (cmd.issued_inc) begin
				issued_q <= issued_q + CNT_W'(1);
			end
			if (cmd.flags_clr_all) begin
				flags_q <= '0;
			end else if (cmd.flag_set) begin
				flags_q[slot] <= 1'b1;
			end else if (cmd.flag_clr) begin
				flags_q[slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			id_q <= entity_id;
		end
		ver_q <= ver_d;
	end

	// output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_sel)
				RES_SLOT: begin
					st_o_q  <= ST_OK;
					id_o_q  <= ID_W'(ptr_q) + ID_W'(1);
					ver_o_q <= ver_q;
					act_o_q <= flags_q[slot];
				end
				RES_NOT_FOUND: begin
					st_o_q  <= ST_NOT_FOUND;
					id_o_q  <= '0;
					ver_o_q <= '0;
					act_o_q <= 1'b0;
				end
				RES_FULL: begin
					st_o_q  <= ST_FULL;
					id_o_q  <= '0;
					ver_o_q <= '0;
					act_o_q <= 1'b0;
				end
				default: begin
					st_o_q  <= ST_OK;
					id_o_q  <= '0;
					ver_o_q <= '0;
					act_o_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid  = out_valid_q;
	assign status    = st_o_q;
	assign result_id = id_o_q;
	assign version   = ver_o_q;
	assign is_active = act_o_q;

	`GSA_ASSERT_IMP(a_issued_max, 1'b1, issued_q <= CNT_W'(NUM_SLOTS), "issued count beyond table")
	`GSA_ASSERT_IMP(a_no_overwrite, out_valid_q && !m_tready, !cmd.out_load, "result lost on stall")
	`GSA_ASSERT_IMP(a_new_at_end, cmd.issued_inc, ptr_at_end && !full, "new id off issued end")
	`GSA_ASSERT_NXT(a_set_active, cmd.flag_set, flags_q[slot], "slot not active after create")

endmodule

`default_nettype wire

// ===== rtl/generational_slot_allocator_top.sv =====
// Generational slot allocator: one request in, one result out.
// Slave channel: s_tuser[1:0] = operation (create, destroy, lookup, clear all),
//   s_tdata[6:0] = one-based entity id, s_tdata[7] unused.
// Master channel: m_tuser[1:0] = status (ok, not found, full),
//   m_tdata[6:0] = result id, [22:7] = version, [23] = active flag.
// One request is in flight at a time; s_tready is high only while the sequencer idles.
// From acceptance to m_tvalid: clear, or an id not found, goes from decode to the output;
// lookup and destroy first read the version RAM; create scans the active flags from
// slot 0 and issues a fresh id at the end of the issued range, reports a full table, or
// reads and rewrites the first inactive slot. The scan tests one active flag per cycle,
// and a reuse waits on the single port of the version RAM. No new request is taken before
// the sequencer is through with the last; s_tready rises the cycle after the result is loaded.
// A finished result sits in the output register, so the next request is accepted while
// the receiver stalls; it stalls only the next result's hand-over, nothing is dropped.
// Reset clears all active flags and the issued count; versions are not cleared and are
// written whenever a slot is issued. No clearing pass is needed after reset.
// Depends on gsa_pkg, gsa_ctrl, gsa_datapath, gsa_ram.
`default_nettype none

module generational_slot_allocator_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gsa_pkg::IN_DATA_W-1:0]     s_tdata,  // entity_id
	input  wire logic [gsa_pkg::FUNC_W-1:0]        s_tuser,  // func
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [gsa_pkg::OUT_DATA_W-1:0]         m_tdata,  // result_id, version, is_active
	output logic [gsa_pkg::ST_W-1:0]               m_tuser   // status
);
	import gsa_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [ID_W-1:0]  result_id;
	logic [VER_W-1:0] version;
	logic             is_active;

	gsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	gsa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.func     (s_tuser),
		.entity_id(s_tdata[ID_W-1:0]),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (m_tuser),
		.result_id(result_id),
		.version  (version),
		.is_active(is_active)
	);

	assign m_tdata = OUT_DATA_W'({is_active, version, result_id});

endmodule

`default_nettype wire
